[rtl/handheld_console_memory_bus_dma_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the console memory bus
// Clocked on clk, disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef HANDHELD_CONSOLE_MEMORY_BUS_DMA_MACROS_SVH
`define HANDHELD_CONSOLE_MEMORY_BUS_DMA_MACROS_SVH

// Same-cycle implication.
`define HCMBD_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("hcmbd: same-cycle check failed");

// Next-cycle implication.
`define HCMBD_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("hcmbd: next-cycle check failed");

`endif

[rtl/hcmbd_pkg.sv]
// ----------------------------------------------------------------------------
// hcmbd_pkg
// Types and fixed constants of the console memory bus with sprite DMA.
// ----------------------------------------------------------------------------
package hcmbd_pkg;

	// bus operations, carried on s_tuser
	typedef enum logic [1:0] {
		OP_READ      = 2'd0,
		OP_WRITE     = 2'd1,
		OP_DMA_TICK  = 2'd2,
		OP_BOOT_LOAD = 2'd3
	} op_t;

	// configuration register indexes (paddr[2])
	localparam logic REG_BOOT_ROM_ENABLE = 1'b0;
	localparam logic REG_VRAM_LOCK       = 1'b1;

	localparam int APB_AW = 3;
	localparam int APB_DW = 32;

	localparam int STORE_AW = 16;  // 65536 bytes
	localparam int BOOT_AW  = 8;   // 256 bytes

	// input word, first field in the high bits
	typedef struct packed {
		logic [3:0]  joypad_buttons;
		logic [3:0]  joypad_dpad;
		logic [15:0] div_count;
		logic [7:0]  data;
		logic [15:0] address;
	} item_t;

	// result word, first field in the high bits
	typedef struct packed {
		logic       dma_busy;
		logic [6:0] serial_char;
		logic       serial_valid;
		logic       div_clear;
		logic [7:0] read_data;
	} res_t;

	localparam int IN_W   = $bits(item_t);
	localparam int USER_W = $bits(op_t);
	localparam int RES_W  = $bits(res_t);
	localparam int OUT_W  = ((RES_W + 7) / 8) * 8;

	// special addresses
	localparam logic [15:0] ADDR_JOYP     = 16'hFF00;
	localparam logic [15:0] ADDR_SB       = 16'hFF01;
	localparam logic [15:0] ADDR_SC       = 16'hFF02;
	localparam logic [15:0] ADDR_TIMER    = 16'hFF04;
	localparam logic [15:0] ADDR_DMA      = 16'hFF46;
	localparam logic [15:0] ADDR_BOOT_OFF = 16'hFF50;
	localparam logic [15:0] BOOT_LIMIT    = 16'h0100;
	localparam logic [15:0] OAM_BASE      = 16'hFE00;
	localparam logic [15:0] OAM_END       = 16'hFEA0;
	localparam logic [15:0] VRAM_BASE     = 16'h8000;
	localparam logic [15:0] VRAM_END      = 16'hA000;
	localparam logic [7:0]  OAM_PAGE      = 8'hFE;

	localparam logic [7:0] SC_START    = 8'h81;
	localparam logic [7:0] JOYP_IDLE   = 8'hCF;
	localparam logic [3:0] NIBBLE_HIGH = 4'hF;
	localparam int         SEL_DPAD    = 4;
	localparam int         SEL_BTN     = 5;
	localparam logic [7:0] BYTE_OPEN   = 8'hFF;

	localparam logic [7:0] CHAR_LF    = 8'd10;
	localparam logic [7:0] CHAR_CR    = 8'd13;
	localparam logic [7:0] CHAR_FIRST = 8'd32;
	localparam logic [7:0] CHAR_LAST  = 8'd126;

	// bytes moved by one sprite-table DMA run
	localparam logic [8:0] DMA_LENGTH = 9'd160;

endpackage

[rtl/handheld_console_memory_bus_dma.sv]
// ----------------------------------------------------------------------------
// handheld_console_memory_bus_dma
// 64 KiB byte bus with boot overlay, special registers and sprite-table DMA.
// ----------------------------------------------------------------------------
// Flow: a word accepted in the idle state is decided in the finish state,
//   and its result enters the output register when that register is free
//   or emptying; a stalled output holds the item in its finish state.
// One word at a time, since the single-port main store is read in the
//   accept cycle and written back in the finish cycle.
// Reset: control clears at once, then a clearing pass zeroes all 65536 bytes
//   of the main store with s_tready low; APB writes are taken throughout.
module handheld_console_memory_bus_dma (
	input  logic                          clk,
	input  logic                          arst_n,
	// stream in
	input  logic                          s_tvalid,
	output logic                          s_tready,
	// address[15:0], data[23:16], div_count[39:24],
	// joypad_dpad[43:40], joypad_buttons[47:44]
	input  logic [hcmbd_pkg::IN_W-1:0]    s_tdata,
	// opcode[1:0]
	input  logic [hcmbd_pkg::USER_W-1:0]  s_tuser,
	// stream out
	output logic                          m_tvalid,
	input  logic                          m_tready,
	// read_data[7:0], div_clear[8], serial_valid[9], serial_char[16:10],
	// dma_busy[17], zero fill [23:18]
	output logic [hcmbd_pkg::OUT_W-1:0]   m_tdata,
	// APB configuration
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [hcmbd_pkg::APB_AW-1:0]  paddr,
	input  logic [hcmbd_pkg::APB_DW-1:0]  pwdata,
	output logic [hcmbd_pkg::APB_DW-1:0]  prdata,
	output logic                          pready
);
	import hcmbd_pkg::*;

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_FINISH
	} state_t;

	state_t                state_q;
	logic [STORE_AW-1:0]   clr_addr_q;

	// configuration and control state
	logic                  boot_en_q;
	logic                  vram_lock_q;
	logic                  overlay_off_q;
	logic                  dma_run_q;
	logic [7:0]            dma_page_q;
	logic [7:0]            dma_pos_q;

	// output register
	logic                  m_tvalid_q;
	res_t                  m_res_q;

	// memories and their read registers
	logic [7:0]            main_store_q [2**STORE_AW];
	logic [7:0]            boot_store_q [2**BOOT_AW];
	logic [7:0]            mem_rdata_q;
	logic [7:0]            boot_rdata_q;

	// item held between the accept and finish cycles
	item_t                 item_s1;
	op_t                   op_s1;

	item_t                 in_item;
	op_t                   in_op;
	logic                  accept;
	logic                  fin_go;
	logic                  cfg_we;

	logic [STORE_AW-1:0]   rd_addr;
	logic [STORE_AW-1:0]   mem_addr;
	logic                  mem_we;
	logic [7:0]            mem_wdata;

	// finish-cycle results
	res_t                  res;
	logic                  wr_en;
	logic [STORE_AW-1:0]   wr_addr;
	logic [7:0]            wr_data;
	logic                  boot_we;
	logic                  off_set;
	logic                  dma_run_d;
	logic [7:0]            dma_page_d;
	logic [7:0]            dma_pos_d;
	logic [8:0]            dma_pos_inc;
	logic                  overlay;
	logic                  in_oam;
	logic                  in_vram;
	logic [7:0]            joyp;

	assign in_item  = item_t'(s_tdata);
	assign in_op    = op_t'(s_tuser);
	assign s_tready = (state_q == ST_IDLE);
	assign accept   = s_tvalid && s_tready;
	// finish only when the output register is free or being emptied
	assign fin_go   = (state_q == ST_FINISH) && (!m_tvalid_q || m_tready);

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {{(OUT_W - RES_W){1'b0}}, m_res_q};

	// APB: no wait states, register picked by paddr[2]
	assign pready = 1'b1;
	assign cfg_we = psel && penable && pwrite && pready;

	always_comb begin
		prdata = '0;
		case (paddr[2])
			REG_BOOT_ROM_ENABLE: prdata[0] = boot_en_q;
			REG_VRAM_LOCK:       prdata[0] = vram_lock_q;
			default:             prdata = '0;
		endcase
	end

	// Read address, chosen in the accept cycle. A serial start needs the
	// pending character from SB; a DMA tick needs its source byte.
	always_comb begin
		case (in_op)
			OP_WRITE: begin
				rd_addr = (in_item.address == ADDR_SC) ? ADDR_SB : in_item.address;
			end
			OP_DMA_TICK: rd_addr = {dma_page_q, dma_pos_q};
			default:     rd_addr = in_item.address;
		endcase
	end

	// One port on the main store: clearing pass, write-back or read. The
	// read of an item and the write-back of the one before never share a
	// cycle, and the next read comes after the write-back, so no forwarding.
	always_comb begin
		if (state_q == ST_CLEAR) begin
			mem_addr  = clr_addr_q;
			mem_we    = 1'b1;
			mem_wdata = '0;
		end else if (state_q == ST_FINISH) begin
			mem_addr  = wr_addr;
			mem_we    = fin_go && wr_en;
			mem_wdata = wr_data;
		end else begin
			mem_addr  = rd_addr;
			mem_we    = 1'b0;
			mem_wdata = wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			main_store_q[mem_addr] <= mem_wdata;
		end else if (accept) begin
			mem_rdata_q <= main_store_q[mem_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (fin_go && boot_we) begin
			boot_store_q[item_s1.address[BOOT_AW-1:0]] <= item_s1.data;
		end else if (accept) begin
			boot_rdata_q <= boot_store_q[in_item.address[BOOT_AW-1:0]];
		end
	end

	// hold the accepted item for the finish cycle
	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= in_item;
			op_s1   <= in_op;
		end
	end

	// Finish cycle: decide the result, the main and boot store writes, the overlay switch-off and the next DMA state.
	always_comb begin
		res         = '0;
		wr_en       = 1'b0;
		wr_addr     = item_s1.address;
		wr_data     = item_s1.data;
		boot_we     = 1'b0;
		off_set     = 1'b0;
		dma_run_d   = dma_run_q;
		dma_page_d  = dma_page_q;
		dma_pos_d   = dma_pos_q;
		dma_pos_inc = {1'b0, dma_pos_q} + 9'd1;
		joyp        = JOYP_IDLE;

		overlay = boot_en_q && !overlay_off_q;
		in_oam  = (item_s1.address >= OAM_BASE) && (item_s1.address < OAM_END);
		in_vram = (item_s1.address >= VRAM_BASE) && (item_s1.address < VRAM_END);

		// joypad matrix: a low select bit lets that group pull lines low
		if (!mem_rdata_q[SEL_DPAD]) begin
			joyp = joyp & {NIBBLE_HIGH, item_s1.joypad_dpad};
		end
		if (!mem_rdata_q[SEL_BTN]) begin
			joyp = joyp & {NIBBLE_HIGH, item_s1.joypad_buttons};
		end

		case (op_s1)
			OP_READ: begin
				if (overlay && (item_s1.address < BOOT_LIMIT)) begin
					res.read_data = boot_rdata_q;
				end else if (item_s1.address == ADDR_TIMER) begin
					res.read_data = item_s1.div_count[15:8];
				end else if (item_s1.address == ADDR_JOYP) begin
					res.read_data = joyp;
				end else if (dma_run_q && in_oam) begin
					res.read_data = BYTE_OPEN;
				end else if (vram_lock_q && in_vram) begin
					res.read_data = BYTE_OPEN;
				end else begin
					res.read_data = mem_rdata_q;
				end
			end
			OP_WRITE: begin
				if (item_s1.address == ADDR_TIMER) begin
					res.div_clear = 1'b1;
					wr_en         = 1'b1;
					wr_data       = '0;
				end else if (item_s1.address == ADDR_DMA) begin
					// restart DMA even when a run is in progress
					wr_en      = 1'b1;
					dma_run_d  = 1'b1;
					dma_page_d = item_s1.data;
					dma_pos_d  = '0;
				end else if ((item_s1.address == ADDR_SC) && (item_s1.data == SC_START)) begin
					if ((mem_rdata_q >= CHAR_FIRST) && (mem_rdata_q <= CHAR_LAST)) begin
						res.serial_valid = 1'b1;
						res.serial_char  = mem_rdata_q[6:0];
					end else if ((mem_rdata_q == CHAR_LF) || (mem_rdata_q == CHAR_CR)) begin
						res.serial_valid = 1'b1;
						res.serial_char  = CHAR_LF[6:0];
					end
					wr_en   = 1'b1;
					wr_data = '0;
				end else if ((item_s1.address == ADDR_BOOT_OFF) && overlay) begin
					off_set = 1'b1;
				end else if (vram_lock_q && in_vram) begin
					wr_en = 1'b0;
				end else if (dma_run_q && in_oam) begin
					wr_en = 1'b0;
				end else begin
					wr_en = 1'b1;
				end
			end
			OP_DMA_TICK: begin
				if (dma_run_q) begin
					wr_en     = 1'b1;
					wr_addr   = {OAM_PAGE, dma_pos_q};
					wr_data   = mem_rdata_q;
					dma_pos_d = dma_pos_inc[7:0];
					if (dma_pos_inc >= DMA_LENGTH) begin
						dma_run_d = 1'b0;
					end
				end
			end
			OP_BOOT_LOAD: boot_we = 1'b1;
			default: ;
		endcase

		res.dma_busy = dma_run_d;
	end

	// control state and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_CLEAR;
			clr_addr_q    <= '0;
			boot_en_q     <= 1'b0;
			vram_lock_q   <= 1'b0;
			overlay_off_q <= 1'b0;
			dma_run_q     <= 1'b0;
			dma_page_q    <= '0;
			dma_pos_q     <= '0;
			m_tvalid_q    <= 1'b0;
			m_res_q       <= '0;
		end else begin
			// writing the boot enable re-arms the overlay
			if (cfg_we) begin
				case (paddr[2])
					REG_BOOT_ROM_ENABLE: begin
						boot_en_q     <= pwdata[0];
						overlay_off_q <= 1'b0;
					end
					REG_VRAM_LOCK: vram_lock_q <= pwdata[0];
					default: ;
				endcase
			end

			// drop valid once taken, unless a new result replaces it
			if (m_tvalid_q && m_tready && !fin_go) begin
				m_tvalid_q <= 1'b0;
			end

			case (state_q)
				ST_CLEAR: begin
					// zero one byte per cycle, then open the input
					clr_addr_q <= STORE_AW'(clr_addr_q + 1'b1);
					if (clr_addr_q == '1) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_FINISH;
					end
				end
				ST_FINISH: begin
					if (fin_go) begin
						state_q    <= ST_IDLE;
						m_tvalid_q <= 1'b1;
						m_res_q    <= res;
						dma_run_q  <= dma_run_d;
						dma_page_q <= dma_page_d;
						dma_pos_q  <= dma_pos_d;
						if (off_set) begin
							overlay_off_q <= 1'b1;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

[rtl/hcmbd_checker.sv]
// ----------------------------------------------------------------------------
// hcmbd_checker
// Port-level checks on the console memory bus, bound to the top level.
// ----------------------------------------------------------------------------
`include "handheld_console_memory_bus_dma_macros.svh"

module hcmbd_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          s_tvalid,
	input logic                          s_tready,
	input logic                          m_tvalid,
	input logic                          m_tready,
	input logic [hcmbd_pkg::OUT_W-1:0]   m_tdata,
	input logic                          psel,
	input logic                          penable,
	input logic                          pwrite,
	input logic                          pready,
	input logic [hcmbd_pkg::APB_AW-1:0]  paddr,
	input logic [hcmbd_pkg::APB_DW-1:0]  pwdata,
	input logic [hcmbd_pkg::APB_DW-1:0]  prdata
);
	import hcmbd_pkg::*;

	res_t res_view;
	logic boot_cfg_wr;

	assign res_view    = res_t'(m_tdata[RES_W-1:0]);
	assign boot_cfg_wr = psel && penable && pwrite && pready &&
		(paddr[2] == REG_BOOT_ROM_ENABLE);

	// a stalled result holds
	`HCMBD_ASSERT_NXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

	// one word in flight: no accept in the cycle after an accept
	`HCMBD_ASSERT_NXT(a_one_in_flight, s_tvalid && s_tready, !s_tready)

	// an emitted character is printable or a line feed; none emitted means zero
	`HCMBD_ASSERT_IMP(a_serial_char, m_tvalid, (res_view.serial_valid && ((res_view.serial_char == 7'd10) || ((res_view.serial_char >= 7'd32) && (res_view.serial_char <= 7'd126)))) || (!res_view.serial_valid && (res_view.serial_char == 7'd0)))

	// write side effects come with a zero read byte
	`HCMBD_ASSERT_IMP(a_write_no_data, m_tvalid && (res_view.serial_valid || res_view.div_clear), res_view.read_data == 8'd0)

	// boot enable reads back what was written
	`HCMBD_ASSERT_NXT(a_boot_cfg_back, boot_cfg_wr, (paddr[2] != REG_BOOT_ROM_ENABLE) || (prdata[0] == $past(pwdata[0])))

endmodule

bind handheld_console_memory_bus_dma hcmbd_checker u_hcmbd_checker (.*);

[tb/sv/handheld_console_memory_bus_dma_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// handheld_console_memory_bus_dma_tb
// Drives reads, writes, DMA ticks and boot loads into the console memory bus.
// Every accepted word is run through a shadow of the bus, and every result
// word is compared field by field with the oldest prediction. A directed part
// is followed by random phases under all register settings.
// ----------------------------------------------------------------------------
module handheld_console_memory_bus_dma_tb;
	import hcmbd_pkg::*;

	localparam int STORE_SIZE   = 1 << STORE_AW;
	localparam int BOOT_SIZE    = 1 << BOOT_AW;
	localparam int PHASE_ITEMS  = 205;
	localparam int LONG_HOLD    = 400;
	localparam int HOLD_AFTER   = 300;
	localparam int SETTLE       = 4;
	localparam int TAIL_CYCLES  = 16;
	// no handshake moves during the clearing pass over the whole store after reset
	localparam int IDLE_LIMIT   = 4 * STORE_SIZE;
	localparam int PRINT_LIMIT  = 40;
	localparam logic [15:0] WORK_BASE = 16'hC000;

	// ------------------------------------------------------------------
	// Shadow of the bus: main store, boot store, overlay and DMA state,
	// plus the queue of results still owed by the block.
	// ------------------------------------------------------------------
	class bus_mirror;
		logic [7:0] main_mem [STORE_SIZE];
		logic [7:0] boot_mem [BOOT_SIZE];
		bit         boot_en;
		bit         vram_lk;
		bit         overlay_off;
		bit         dma_on;
		logic [7:0] dma_page;
		logic [7:0] dma_pos;
		res_t       owed_results [$];
		int         fail_count;
		int         result_no;

		function new();
			for (int i = 0; i < STORE_SIZE; i++) main_mem[i] = 8'h00;
			for (int i = 0; i < BOOT_SIZE; i++) boot_mem[i] = 8'h00;
			boot_en = 0;
			vram_lk = 0;
			overlay_off = 0;
			dma_on = 0;
			dma_page = 8'h00;
			dma_pos = 8'h00;
			fail_count = 0;
			result_no = 0;
		endfunction

		function int pending();
			return owed_results.size();
		endfunction

		function void set_reg(logic idx, bit val);
			if (idx == REG_BOOT_ROM_ENABLE) begin
				boot_en = val;
				overlay_off = 0;
			end else begin
				vram_lk = val;
			end
		endfunction

		function logic [7:0] bus_peek(item_t it);
			logic [7:0]  sel;
			logic [7:0]  v;
			logic [15:0] a;
			a = it.address;
			if (boot_en && !overlay_off && a < BOOT_LIMIT) return boot_mem[a[7:0]];
			if (a == ADDR_TIMER) return it.div_count[15:8];
			if (a == ADDR_JOYP) begin
				sel = main_mem[ADDR_JOYP];
				v = JOYP_IDLE;
				if (!sel[SEL_DPAD]) v = v & {NIBBLE_HIGH, it.joypad_dpad};
				if (!sel[SEL_BTN]) v = v & {NIBBLE_HIGH, it.joypad_buttons};
				return v;
			end
			if (dma_on && a >= OAM_BASE && a < OAM_END) return BYTE_OPEN;
			if (vram_lk && a >= VRAM_BASE && a < VRAM_END) return BYTE_OPEN;
			return main_mem[a];
		endfunction

		function void bus_poke(logic [15:0] a, logic [7:0] v, inout res_t r);
			logic [7:0] c;
			if (a == ADDR_TIMER) begin
				r.div_clear = 1'b1;
				main_mem[a] = 8'h00;
			end else if (a == ADDR_DMA) begin
				main_mem[a] = v;
				dma_on = 1;
				dma_page = v;
				dma_pos = 8'h00;
			end else if (a == ADDR_SC && v == SC_START) begin
				c = main_mem[ADDR_SB];
				if (c >= CHAR_FIRST && c <= CHAR_LAST) begin
					r.serial_valid = 1'b1;
					r.serial_char = c[6:0];
				end else if (c == CHAR_LF || c == CHAR_CR) begin
					r.serial_valid = 1'b1;
					r.serial_char = 7'(CHAR_LF);
				end
				main_mem[ADDR_SC] = 8'h00;
			end else if (a == ADDR_BOOT_OFF && boot_en && !overlay_off) begin
				overlay_off = 1;
			end else if (vram_lk && a >= VRAM_BASE && a < VRAM_END) begin
				// dropped
			end else if (dma_on && a >= OAM_BASE && a < OAM_END) begin
				// dropped
			end else begin
				main_mem[a] = v;
			end
		endfunction

		function void dma_copy_one();
			logic [15:0] src;
			logic [15:0] dst;
			logic [8:0]  nxt;
			if (dma_on) begin
				src = {dma_page, 8'h00} + {8'h00, dma_pos};
				dst = OAM_BASE + {8'h00, dma_pos};
				main_mem[dst] = main_mem[src];
				nxt = {1'b0, dma_pos} + 9'd1;
				if (nxt >= DMA_LENGTH) dma_on = 0;
				dma_pos = nxt[7:0];
			end
		endfunction

		// advance the shadow by one accepted word and queue what it owes
		function void take_request(op_t op, item_t it);
			res_t r;
			r = '0;
			case (op)
				OP_READ:      r.read_data = bus_peek(it);
				OP_WRITE:     bus_poke(it.address, it.data, r);
				OP_DMA_TICK:  dma_copy_one();
				OP_BOOT_LOAD: boot_mem[it.address[7:0]] = it.data;
				default: ;
			endcase
			r.dma_busy = dma_on;
			owed_results.push_back(r);
		endfunction

		task report(string msg);
			if (fail_count < PRINT_LIMIT) $display("MISMATCH: %s", msg);
			fail_count++;
		endtask

		task cmp(string name, int got, int want);
			if (got != want)
				report($sformatf("result %0d %s got 0x%0h want 0x%0h",
					result_no, name, got, want));
		endtask

		task match_response(logic [OUT_W-1:0] word);
			res_t got;
			res_t want;
			got = word[RES_W-1:0];
			if (owed_results.size() == 0) begin
				report($sformatf("result %0d arrived with none owed", result_no));
			end else begin
				want = owed_results.pop_front();
				cmp("read_data", got.read_data, want.read_data);
				cmp("div_clear", got.div_clear, want.div_clear);
				cmp("serial_valid", got.serial_valid, want.serial_valid);
				cmp("serial_char", got.serial_char, want.serial_char);
				cmp("dma_busy", got.dma_busy, want.dma_busy);
			end
			result_no++;
		endtask
	endclass

	// ------------------------------------------------------------------
	// Block connections
	// ------------------------------------------------------------------
	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 s_tvalid = 1'b0;
	logic                 s_tready;
	logic [IN_W-1:0]      s_tdata = '0;
	logic [USER_W-1:0]    s_tuser = '0;
	logic                 m_tvalid;
	logic                 m_tready = 1'b0;
	logic [OUT_W-1:0]     m_tdata;
	logic                 psel = 1'b0;
	logic                 penable = 1'b0;
	logic                 pwrite = 1'b0;
	logic [APB_AW-1:0]    paddr = '0;
	logic [APB_DW-1:0]    pwdata = '0;
	logic [APB_DW-1:0]    prdata;
	logic                 pready;

	handheld_console_memory_bus_dma DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	always #4 clk = ~clk;

	bus_mirror sb;

	// generator-side bookkeeping: which boot entries have been loaded, and
	// whether the overlay may be live, so no unloaded entry is ever read
	bit cfg_boot = 1'b0;
	bit boot_loaded [BOOT_SIZE];
	int burst_left = 0;
	int phase_items = 0;

	// ------------------------------------------------------------------
	// Monitors: sample both handshakes at the edge, before the block's
	// own updates of that edge land.
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		if (arst_n && s_tvalid && s_tready) sb.take_request(op_t'(s_tuser), item_t'(s_tdata));
		if (arst_n && m_tvalid && m_tready) sb.match_response(m_tdata);
	end

	// Watchdog: count quiet cycles, give up when nothing moves for too long.
	int idle_cycles = 0;
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// Receiver: switch between stall patterns every so often, and once,
	// after a few hundred results, hold off for a long stretch so the
	// block backs up and drops s_tready.
	// ------------------------------------------------------------------
	int  rx_mode = 0;
	int  rx_mode_left = 0;
	int  rx_tick = 0;
	int  rx_taken = 0;
	int  hold_left = 0;
	bit  hold_done = 1'b0;

	always @(posedge clk) begin
		if (m_tvalid && m_tready) rx_taken++;
		if (rx_mode_left == 0) begin
			rx_mode = $urandom_range(0, 3);
			rx_mode_left = $urandom_range(20, 120);
		end
		rx_mode_left--;
		rx_tick++;
		if (hold_left != 0) begin
			hold_left--;
			m_tready <= 1'b0;
		end else if (!hold_done && rx_taken >= HOLD_AFTER) begin
			hold_done = 1'b1;
			hold_left = LONG_HOLD;
			m_tready <= 1'b0;
		end else begin
			case (rx_mode)
				0: m_tready <= 1'b1;
				1: m_tready <= 1'($urandom_range(0, 1));
				2: m_tready <= (rx_tick % 5) < 3;
				default: m_tready <= ($urandom_range(0, 3) == 0);
			endcase
		end
	end

	// ------------------------------------------------------------------
	// Sender
	// ------------------------------------------------------------------

	// Offer one word and hold it until accepted. Valid stays high on return
	// so a back-to-back word needs no second assignment in the same step.
	task automatic send_word(op_t op, item_t it);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap != 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		s_tvalid <= 1'b1;
		s_tuser <= op;
		s_tdata <= it;
		do @(posedge clk); while (!s_tready);
	endtask

	// Build a word with random timer and joypad lines. A read that could
	// hit an unloaded boot entry becomes a load of that entry instead.
	task automatic send(op_t op, logic [15:0] addr, logic [7:0] val);
		item_t it;
		if (op == OP_READ && cfg_boot && addr < BOOT_LIMIT && !boot_loaded[addr[7:0]])
			op = OP_BOOT_LOAD;
		if (op == OP_BOOT_LOAD) boot_loaded[addr[7:0]] = 1'b1;
		it.address = addr;
		it.data = val;
		it.div_count = 16'($urandom_range(0, 65535));
		it.joypad_dpad = 4'($urandom_range(0, 15));
		it.joypad_buttons = 4'($urandom_range(0, 15));
		send_word(op, it);
		phase_items++;
	endtask

	// Drop valid and wait until every owed result is in, then settle.
	// Check the count between edges, after the monitor has run.
	task automatic drain();
		s_tvalid <= 1'b0;
		do @(negedge clk); while (sb.pending() != 0);
		repeat (SETTLE) @(posedge clk);
	endtask

	// Setup phase, then access phase held until pready, then idle before the next transfer.
	task automatic apb_write(logic idx, logic [APB_DW-1:0] val);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		sb.set_reg(idx, val[0]);
		@(posedge clk);
	endtask

	task automatic set_phase(bit ben, bit vl);
		drain();
		apb_write(REG_BOOT_ROM_ENABLE, {31'd0, ben});
		apb_write(REG_VRAM_LOCK, {31'd0, vl});
		cfg_boot = ben;
	endtask

	function automatic logic [7:0] rand_byte();
		return 8'($urandom_range(0, 255));
	endfunction

	// SB contents for a serial send: printable, line ends, and junk
	function automatic logic [7:0] serial_byte();
		case ($urandom_range(0, 5))
			0: return CHAR_LF;
			1: return CHAR_CR;
			2: return 8'($urandom_range(0, 31));
			3: return 8'($urandom_range(127, 255));
			default: return 8'($urandom_range(32, 126));
		endcase
	endfunction

	function automatic logic [7:0] dma_page();
		case ($urandom_range(0, 5))
			0: return OAM_PAGE;
			1: return 8'hFF;
			2: return 8'h00;
			3, 4: return WORK_BASE[15:8];
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	function automatic op_t pick_op();
		int w;
		w = $urandom_range(0, 19);
		if (w < 9) return OP_READ;
		if (w < 17) return OP_WRITE;
		if (w < 19) return OP_DMA_TICK;
		return OP_BOOT_LOAD;
	endfunction

	// Bias addresses toward special registers and region edges.
	function automatic logic [15:0] pick_addr();
		case ($urandom_range(0, 9))
			0: begin
				case ($urandom_range(0, 5))
					0: return ADDR_JOYP;
					1: return ADDR_SB;
					2: return ADDR_SC;
					3: return ADDR_TIMER;
					4: return ADDR_DMA;
					default: return ADDR_BOOT_OFF;
				endcase
			end
			1: return OAM_BASE + 16'($urandom_range(0, 'hBF));
			2: return VRAM_BASE - 16'd16 + 16'($urandom_range(0, 'h1F));
			3: return VRAM_END - 16'd16 + 16'($urandom_range(0, 'h1F));
			4: return 16'($urandom_range(VRAM_BASE, VRAM_END - 1));
			5: return 16'($urandom_range(0, 'h1FF));
			6, 7: return WORK_BASE + 16'($urandom_range(0, 'hFF));
			8: return ADDR_JOYP + 16'($urandom_range(0, 'hFF));
			default: return 16'($urandom_range(0, 65535));
		endcase
	endfunction

	// One sprite-table copy: start it, then mostly ticks, with reads and
	// writes into the blocked table and now and then a restart.
	task automatic dma_run();
		int ticks;
		int steps;
		send(OP_WRITE, ADDR_DMA, dma_page());
		ticks = 0;
		steps = 0;
		while (ticks < DMA_LENGTH + 2 && steps < 400) begin
			steps++;
			case ($urandom_range(0, 9))
				0: send(OP_READ, OAM_BASE + 16'($urandom_range(0, 'hBF)), rand_byte());
				1: send(OP_WRITE, OAM_BASE + 16'($urandom_range(0, 'hBF)), rand_byte());
				2: send(pick_op(), pick_addr(), rand_byte());
				default: begin
					send(OP_DMA_TICK, 16'($urandom_range(0, 65535)), rand_byte());
					ticks++;
				end
			endcase
			if ($urandom_range(0, 199) == 0) begin
				send(OP_WRITE, ADDR_DMA, dma_page());
				ticks = 0;
			end
		end
	endtask

	task automatic random_sequence();
		int kind;
		kind = $urandom_range(0, 39);
		if (kind == 0) begin
			dma_run();
		end else if (kind < 6) begin
			// serial send: fill SB, then kick SC (mostly with the start value)
			send(OP_WRITE, ADDR_SB, serial_byte());
			send(OP_WRITE, ADDR_SC, ($urandom_range(0, 3) != 0) ? SC_START : rand_byte());
		end else if (kind < 11) begin
			// joypad: pick the selected nibbles, then poll
			send(OP_WRITE, ADDR_JOYP, rand_byte());
			repeat ($urandom_range(1, 3)) send(OP_READ, ADDR_JOYP, rand_byte());
		end else if (kind < 14) begin
			// boot overlay: load, read the low page, maybe switch it off
			repeat ($urandom_range(1, 4))
				send(OP_BOOT_LOAD, 16'($urandom_range(0, 65535)), rand_byte());
			repeat ($urandom_range(1, 4))
				send(OP_READ, 16'($urandom_range(0, 'h120)), rand_byte());
			if ($urandom_range(0, 1) == 0) send(OP_WRITE, ADDR_BOOT_OFF, rand_byte());
		end else if (kind < 17) begin
			// noise: any operation on any address
			send(op_t'($urandom_range(0, 3)), 16'($urandom_range(0, 65535)), rand_byte());
		end else begin
			repeat ($urandom_range(2, 10)) send(pick_op(), pick_addr(), rand_byte());
		end
	endtask

	// Edge cases with the overlay armed and video RAM open.
	task automatic directed_items();
		send(OP_BOOT_LOAD, 16'h0000, 8'hA5);
		send(OP_BOOT_LOAD, 16'h00FF, 8'h5A);
		send(OP_BOOT_LOAD, 16'h1234, 8'h3C);         // index wraps to the low byte
		send(OP_READ, 16'h0000, 8'h00);
		send(OP_READ, 16'h00FF, 8'h00);
		send(OP_READ, 16'h0034, 8'h00);
		send(OP_WRITE, ADDR_BOOT_OFF, 8'h01);        // overlay off, nothing stored
		send(OP_READ, 16'h0000, 8'h00);
		send(OP_WRITE, ADDR_TIMER, 8'hFF);
		send(OP_READ, ADDR_TIMER, 8'h00);
		send(OP_WRITE, ADDR_JOYP, 8'h20);            // direction lines selected
		send(OP_READ, ADDR_JOYP, 8'h00);
		send(OP_WRITE, ADDR_JOYP, 8'h10);            // button lines selected
		send(OP_READ, ADDR_JOYP, 8'h00);
		send(OP_WRITE, ADDR_SB, 8'h41);
		send(OP_WRITE, ADDR_SC, SC_START);
		send(OP_WRITE, ADDR_SB, CHAR_CR);
		send(OP_WRITE, ADDR_SC, SC_START);
		send(OP_WRITE, ADDR_SB, 8'h7F);              // not printable, nothing sent
		send(OP_WRITE, ADDR_SC, SC_START);
		send(OP_DMA_TICK, 16'h0000, 8'h00);          // tick with DMA idle
		send(OP_WRITE, WORK_BASE, 8'h77);
		send(OP_WRITE, ADDR_DMA, WORK_BASE[15:8]);
		send(OP_READ, OAM_BASE, 8'h00);              // blocked while copying
		send(OP_WRITE, OAM_BASE, 8'h12);             // dropped while copying
		send(OP_DMA_TICK, 16'hFFFF, 8'hFF);
		send(OP_WRITE, 16'hFFFF, 8'hFF);
		send(OP_READ, 16'hFFFF, 8'h00);
	endtask

	// ------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------
	initial begin
		sb = new();
		for (int i = 0; i < BOOT_SIZE; i++) boot_loaded[i] = 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// directed part with the overlay armed
		set_phase(1'b1, 1'b0);
		directed_items();

		// random phases: every register setting, extremes first
		for (int p = 0; p < 6; p++) begin
			case (p)
				0: set_phase(1'b0, 1'b0);
				1: set_phase(1'b1, 1'b1);
				2: set_phase(1'b0, 1'b1);
				3: set_phase(1'b1, 1'b0);
				default: set_phase(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
			endcase
			phase_items = 0;
			if (p == 0) dma_run();
			while (phase_items < PHASE_ITEMS) random_sequence();
		end

		// let the last results drain, then watch for strays
		drain();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (sb.fail_count == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule
